// ===== rtl/ccd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Checked container deframer package
// Shared types, constants and the CRC-32 and header check functions.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam int unsigned HDR_BYTES    = 32;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned TDATA_BITS   = 152;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_TYPE    = 3'd4,
    ST_HDR_CRC = 3'd5,
    ST_PAY_CRC = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAGIC   = 3'd0,
    REG_VERSION = 3'd1,
    REG_TYPE_A  = 3'd2,
    REG_TYPE_B  = 3'd3,
    REG_TYPE_C  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  type_a;
    logic [7:0]  type_b;
    logic [7:0]  type_c;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    status_e     status;
    logic [63:0] orig_len;
    logic [63:0] pay_len;
    logic [7:0]  type_code;
  } result_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic status_e hdr_status(cfg_t cfg, logic [31:0] magic, logic [7:0] ver,
                                         logic [7:0] typ, logic [31:0] crc_run,
                                         logic [31:0] crc_stored);
    status_e st;
    if (magic != cfg.magic) begin
      st = ST_MAGIC;
    end else if (ver != cfg.version) begin
      st = ST_VERSION;
    end else if (typ != cfg.type_a && typ != cfg.type_b && typ != cfg.type_c) begin
      st = ST_TYPE;
    end else if ((crc_run ^ CRC_ONES) != crc_stored) begin
      st = ST_HDR_CRC;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/checked_container_deframer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Checked container deframer
// Checks a CRC-32 protected container byte by byte and forwards its payload.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: stream_byte; tlast: end_of_stream
//  m_axis    out        tuser: result_kind; tdata: payload and status record
//  cfg       in         write enable, register index, 32-bit write data
//
// One byte is taken every cycle while s_axis_tready is high.
// The byte is processed combinationally between the parser state and the
// result register, where the bytewise CRC step sets the path.
// A stalled result register holds s_axis_tready low only while it is full.
// Reset clears parser and result valid; each final byte clears the parser.
// ----------------------------------------------------------------------------
module checked_container_deframer_core #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // [7:0] stream_byte
  input  wire logic [7:0]                              s_axis_tdata,
  input  wire logic                                    s_axis_tlast,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // [7:0] payload_byte, [10:8] check_status, [74:11] original_length,
  // [138:75] payload_length, [146:139] type_code, [151:147] zero
  output logic [ccd_pkg::TDATA_BITS-1:0]               m_axis_tdata,
  // [0] result_kind
  output logic                                         m_axis_tuser,
  input  wire logic                                    cfg_we_i,
  input  wire logic [ccd_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  wire logic [31:0]                             cfg_data_i
);

  ccd_pkg::cfg_t    cfg;
  ccd_pkg::result_t res;
  ccd_pkg::result_t out_res;
  logic             res_valid;
  logic             accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  ccd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ccd_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ccd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {5'd0, out_res.type_code, out_res.pay_len, out_res.orig_len,
                         out_res.status, out_res.payload};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the result register is empty");

  a_last_gives_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (m_axis_tvalid && m_axis_tuser))
    else $error("final byte did not produce a status record");

  a_payload_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[151:8] == 144'd0))
    else $error("forwarded byte carries nonzero record fields");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:8] != 3'd7))
    else $error("status code out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/ccd_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the expected magic, version and accepted type codes.
// ----------------------------------------------------------------------------
module ccd_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ccd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [31:0]                        cfg_data_i,
  output ccd_pkg::cfg_t                           cfg_o
);

  ccd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ccd_pkg::REG_MAGIC:   cfg_d.magic   = cfg_data_i;
        ccd_pkg::REG_VERSION: cfg_d.version = cfg_data_i[7:0];
        ccd_pkg::REG_TYPE_A:  cfg_d.type_a  = cfg_data_i[7:0];
        ccd_pkg::REG_TYPE_B:  cfg_d.type_b  = cfg_data_i[7:0];
        ccd_pkg::REG_TYPE_C:  cfg_d.type_c  = cfg_data_i[7:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic   <= 32'd0;
      cfg_q.version <= 8'd1;
      cfg_q.type_a  <= 8'd0;
      cfg_q.type_b  <= 8'd1;
      cfg_q.type_c  <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/ccd_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Container parser
// Tracks the byte position, collects the header, runs both CRCs and forms
// one result per accepted byte where one is due.
// ----------------------------------------------------------------------------
module ccd_parser #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          last_i,
  input  wire ccd_pkg::cfg_t cfg_i,
  output logic               res_valid_o,
  output ccd_pkg::result_t   res_o
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_HDR = POSITION_BITS'(ccd_pkg::HDR_BYTES);
  localparam logic [POSITION_BITS-1:0] POS_MIN_LAST = POSITION_BITS'(35);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [31:0] magic_q, magic_d;
  logic [7:0]  ver_q, ver_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] orig_q, orig_d;
  logic [63:0] len_q, len_d;
  logic [31:0] hcrc_st_q, hcrc_st_d;
  logic [31:0] hcrc_q, hcrc_d;
  logic [31:0] pcrc_q, pcrc_d;
  logic [31:0] pcrc_st_q, pcrc_st_d;

  logic                     in_hdr;
  logic [4:0]               hpos;
  logic [7:0]               crc_in;
  logic [POSITION_BITS-1:0] off;
  logic [64:0]              diff;
  logic                     in_payload;
  logic                     in_crc;
  logic                     below_end;
  logic                     forward;
  ccd_pkg::status_e         hdr_now;
  ccd_pkg::status_e         hdr_next;
  ccd_pkg::status_e         status;

  assign in_hdr     = pos_q < POS_HDR;
  assign hpos       = pos_q[4:0];
  assign crc_in     = (hpos == 5'd7 || hpos >= 5'd24) ? 8'd0 : byte_i;
  assign off        = pos_q - POS_HDR;
  assign diff       = {1'b0, 64'(off)} - {1'b0, len_q};
  assign in_payload = !in_hdr && diff[64];
  assign in_crc     = !in_hdr && !diff[64] && (diff[63:2] == 62'd0);
  assign below_end  = diff[64] || ((diff[63:2] == 62'd0) && (diff[1:0] != 2'd3));

  assign hdr_now = ccd_pkg::hdr_status(cfg_i, magic_q, ver_q, type_q, hcrc_q, hcrc_st_q);
  assign forward = in_payload && (hdr_now == ccd_pkg::ST_OK);

  always_comb begin
    magic_d   = magic_q;
    ver_d     = ver_q;
    type_d    = type_q;
    orig_d    = orig_q;
    len_d     = len_q;
    hcrc_st_d = hcrc_st_q;
    hcrc_d    = hcrc_q;
    pcrc_d    = pcrc_q;
    pcrc_st_d = pcrc_st_q;
    pos_d     = (pos_q != POS_MAX) ? pos_q + POSITION_BITS'(1) : pos_q;
    if (in_hdr) begin
      hcrc_d = ccd_pkg::crc_byte(hcrc_q, crc_in);
      if (hpos < 5'd4) begin
        magic_d = magic_q | (32'(byte_i) << {hpos[1:0], 3'b000});
      end else if (hpos == 5'd4) begin
        ver_d = byte_i;
      end else if (hpos == 5'd5) begin
        type_d = byte_i;
      end else if (hpos >= 5'd8 && hpos < 5'd16) begin
        orig_d = orig_q | (64'(byte_i) << {hpos[2:0], 3'b000});
      end else if (hpos >= 5'd16 && hpos < 5'd24) begin
        len_d = len_q | (64'(byte_i) << {hpos[2:0], 3'b000});
      end else if (hpos >= 5'd24 && hpos < 5'd28) begin
        hcrc_st_d = hcrc_st_q | (32'(byte_i) << {hpos[1:0], 3'b000});
      end
    end else if (in_payload) begin
      pcrc_d = ccd_pkg::crc_byte(pcrc_q, byte_i);
    end else if (in_crc) begin
      pcrc_st_d = pcrc_st_q | (32'(byte_i) << {diff[1:0], 3'b000});
    end
  end

  assign hdr_next = ccd_pkg::hdr_status(cfg_i, magic_d, ver_d, type_d, hcrc_d, hcrc_st_d);

  always_comb begin
    if (pos_q < POS_MIN_LAST) begin
      status = ccd_pkg::ST_SHORT;
    end else if (hdr_next != ccd_pkg::ST_OK) begin
      status = hdr_next;
    end else if (below_end) begin
      status = ccd_pkg::ST_SHORT;
    end else if ((pcrc_d ^ ccd_pkg::CRC_ONES) != pcrc_st_d) begin
      status = ccd_pkg::ST_PAY_CRC;
    end else begin
      status = ccd_pkg::ST_OK;
    end
  end

  always_comb begin
    res_valid_o = accept_i && (last_i || forward);
    if (last_i) begin
      res_o.kind      = 1'b1;
      res_o.payload   = 8'd0;
      res_o.status    = status;
      res_o.orig_len  = orig_d;
      res_o.pay_len   = len_d;
      res_o.type_code = type_d;
    end else begin
      res_o.kind      = 1'b0;
      res_o.payload   = byte_i;
      res_o.status    = ccd_pkg::ST_OK;
      res_o.orig_len  = 64'd0;
      res_o.pay_len   = 64'd0;
      res_o.type_code = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      magic_q   <= 32'd0;
      ver_q     <= 8'd0;
      type_q    <= 8'd0;
      orig_q    <= 64'd0;
      len_q     <= 64'd0;
      hcrc_st_q <= 32'd0;
      hcrc_q    <= ccd_pkg::CRC_ONES;
      pcrc_q    <= ccd_pkg::CRC_ONES;
      pcrc_st_q <= 32'd0;
    end else if (accept_i) begin
      if (last_i) begin
        pos_q     <= '0;
        magic_q   <= 32'd0;
        ver_q     <= 8'd0;
        type_q    <= 8'd0;
        orig_q    <= 64'd0;
        len_q     <= 64'd0;
        hcrc_st_q <= 32'd0;
        hcrc_q    <= ccd_pkg::CRC_ONES;
        pcrc_q    <= ccd_pkg::CRC_ONES;
        pcrc_st_q <= 32'd0;
      end else begin
        pos_q     <= pos_d;
        magic_q   <= magic_d;
        ver_q     <= ver_d;
        type_q    <= type_d;
        orig_q    <= orig_d;
        len_q     <= len_d;
        hcrc_st_q <= hcrc_st_d;
        hcrc_q    <= hcrc_d;
        pcrc_q    <= pcrc_d;
        pcrc_st_q <= pcrc_st_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ccd_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ccd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire ccd_pkg::result_t in_data_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ccd_pkg::result_t      out_data_o
);

  logic             valid_q;
  ccd_pkg::result_t data_q;

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

// ===== tb/checked_container_deframer_core_test.sv =====
// ----------------------------------------------------------------------------
// Checked container deframer testbench
// Drives byte streams into the deframer, a few short ones first and then
// whole containers with random content and at most one flaw each (bad magic,
// version, type or CRCs, cut streams, huge lengths, trailing bytes, noise).
// A predictor of its own computes the forwarded payload and the status
// records, and a monitor compares every result transfer field by field.
// Both sides idle at random in the first two of three phases, each under different register settings.
// ----------------------------------------------------------------------------
module checked_container_deframer_core_test;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned TARGET_BYTES = 330;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MIN_STREAMS  = 4;

  localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC32_MASK = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_LIMIT  = 32'hFFFF_FFFF;

  localparam int unsigned VERSION_OFFSET  = 4;
  localparam int unsigned TYPE_OFFSET     = 5;
  localparam int unsigned PAD_OFFSET      = 7;
  localparam int unsigned ORIG_OFFSET     = 8;
  localparam int unsigned LEN_OFFSET      = 16;
  localparam int unsigned HCRC_OFFSET     = 24;
  localparam int unsigned PAD_TAIL_OFFSET = 28;
  localparam int unsigned CRC_BYTES       = 4;
  localparam int unsigned MIN_FRAME       = ccd_pkg::HDR_BYTES + CRC_BYTES;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum int {
    FR_GOOD, FR_TRAILING, FR_CUT_HEADER, FR_CUT_PAYLOAD, FR_BAD_MAGIC, FR_BAD_VERSION,
    FR_BAD_TYPE, FR_BAD_HDR_CRC, FR_BAD_PAY_CRC, FR_HUGE_LENGTH, FR_NOISE
  } frame_flaw_e;

  localparam int unsigned FLAW_ROTATION = int'(FR_NOISE) + 2;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } in_xfer_t;

  typedef struct {
    logic              kind;
    logic [7:0]        payload;
    ccd_pkg::status_e  status;
    logic [63:0]       orig_len;
    logic [63:0]       pay_len;
    logic [7:0]        type_code;
  } deframe_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [7:0]                          s_axis_tdata  = '0;
  logic                                s_axis_tlast  = 1'b0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [ccd_pkg::TDATA_BITS-1:0]      m_axis_tdata;
  logic                                m_axis_tuser;
  logic                                cfg_we_i      = 1'b0;
  logic [ccd_pkg::CFG_IDX_BITS-1:0]    cfg_index_i   = '0;
  logic [31:0]                         cfg_data_i    = '0;

  // Register copies, at their reset values.
  logic [31:0] cfg_magic   = 32'd0;
  logic [7:0]  cfg_version = 8'd1;
  logic [7:0]  cfg_type_a  = 8'd0;
  logic [7:0]  cfg_type_b  = 8'd1;
  logic [7:0]  cfg_type_c  = 8'd2;

  // Parser state of the predictor.
  logic [31:0] pos_q       = '0;
  logic [31:0] magic_acc   = '0;
  logic [7:0]  version_acc = '0;
  logic [7:0]  type_acc    = '0;
  logic [63:0] orig_acc    = '0;
  logic [63:0] len_acc     = '0;
  logic [31:0] hcrc_stored = '0;
  logic [31:0] hcrc_run    = CRC32_MASK;
  logic [31:0] pcrc_run    = CRC32_MASK;
  logic [31:0] pcrc_stored = '0;

  in_xfer_t        pending_xfers[$];
  deframe_result_t expected_results[$];
  logic [7:0]      stage_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        xfer_taken    = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned errors        = 0;
  int unsigned bytes_accepted = 0;
  int unsigned bytes_queued  = 0;
  int unsigned streams_built = 0;
  int unsigned payload_checked = 0;
  int unsigned records_checked = 0;
  logic [7:0]  statuses_seen = '0;

  checked_container_deframer_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC32_POLY & {32{c[0] ^ data[k]}});
    end
    return c;
  endfunction

  function automatic ccd_pkg::status_e header_verdict();
    if (magic_acc != cfg_magic) begin
      return ccd_pkg::ST_MAGIC;
    end
    if (version_acc != cfg_version) begin
      return ccd_pkg::ST_VERSION;
    end
    if (type_acc != cfg_type_a && type_acc != cfg_type_b && type_acc != cfg_type_c) begin
      return ccd_pkg::ST_TYPE;
    end
    if ((hcrc_run ^ CRC32_MASK) != hcrc_stored) begin
      return ccd_pkg::ST_HDR_CRC;
    end
    return ccd_pkg::ST_OK;
  endfunction

  task automatic clear_parser();
    pos_q       = '0;
    magic_acc   = '0;
    version_acc = '0;
    type_acc    = '0;
    orig_acc    = '0;
    len_acc     = '0;
    hcrc_stored = '0;
    hcrc_run    = CRC32_MASK;
    pcrc_run    = CRC32_MASK;
    pcrc_stored = '0;
  endtask

  task automatic deframe_step(input in_xfer_t x);
    logic [31:0]       p;
    logic [63:0]       off;
    logic              fwd;
    ccd_pkg::status_e  st;
    deframe_result_t   r;
    p   = pos_q;
    fwd = 1'b0;
    if (p < ccd_pkg::HDR_BYTES) begin
      hcrc_run = crc32_update(hcrc_run, (p == PAD_OFFSET || p >= HCRC_OFFSET) ? 8'h00 : x.data);
      if (p < VERSION_OFFSET) begin
        magic_acc = magic_acc | (32'(x.data) << (8 * p));
      end else if (p == VERSION_OFFSET) begin
        version_acc = x.data;
      end else if (p == TYPE_OFFSET) begin
        type_acc = x.data;
      end else if (p >= ORIG_OFFSET && p < LEN_OFFSET) begin
        orig_acc = orig_acc | (64'(x.data) << (8 * (p - ORIG_OFFSET)));
      end else if (p >= LEN_OFFSET && p < HCRC_OFFSET) begin
        len_acc = len_acc | (64'(x.data) << (8 * (p - LEN_OFFSET)));
      end else if (p >= HCRC_OFFSET && p < PAD_TAIL_OFFSET) begin
        hcrc_stored = hcrc_stored | (32'(x.data) << (8 * (p - HCRC_OFFSET)));
      end
    end else begin
      off = 64'(p) - ccd_pkg::HDR_BYTES;
      if (off < len_acc) begin
        pcrc_run = crc32_update(pcrc_run, x.data);
        fwd      = (header_verdict() == ccd_pkg::ST_OK);
      end else if (off - len_acc < CRC_BYTES) begin
        pcrc_stored = pcrc_stored | (32'(x.data) << (8 * (off - len_acc)));
      end
    end
    if (p < POS_LIMIT) begin
      pos_q = p + 1;
    end
    r.kind      = KIND_PAYLOAD;
    r.payload   = x.data;
    r.status    = ccd_pkg::ST_OK;
    r.orig_len  = '0;
    r.pay_len   = '0;
    r.type_code = '0;
    if (!x.last) begin
      if (fwd) begin
        expected_results.insert(expected_results.size(), r);
      end
    end else begin
      if (64'(p) + 1 < MIN_FRAME) begin
        st = ccd_pkg::ST_SHORT;
      end else begin
        st = header_verdict();
        if (st == ccd_pkg::ST_OK) begin
          if (64'(p) + 1 - MIN_FRAME < len_acc) begin
            st = ccd_pkg::ST_SHORT;
          end else if ((pcrc_run ^ CRC32_MASK) != pcrc_stored) begin
            st = ccd_pkg::ST_PAY_CRC;
          end
        end
      end
      r.kind      = KIND_STATUS;
      r.payload   = '0;
      r.status    = st;
      r.orig_len  = orig_acc;
      r.pay_len   = len_acc;
      r.type_code = type_acc;
      expected_results.insert(expected_results.size(), r);
      clear_parser();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    errors++;
  endtask

  task automatic check_result();
    deframe_result_t want;
    logic [2:0]      got_status;
    got_status = m_axis_tdata[10:8];
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: kind %0b tdata %h, expected none", $time,
               m_axis_tuser, m_axis_tdata);
      errors++;
    end else begin
      want = expected_results.pop_front();
      if (m_axis_tuser !== want.kind) begin
        note_mismatch("result_kind", 64'(want.kind), 64'(m_axis_tuser));
      end
      if (m_axis_tdata[7:0] !== want.payload) begin
        note_mismatch("payload_byte", 64'(want.payload), 64'(m_axis_tdata[7:0]));
      end
      if (got_status !== want.status) begin
        note_mismatch("check_status", 64'(want.status), 64'(got_status));
      end
      if (m_axis_tdata[74:11] !== want.orig_len) begin
        note_mismatch("original_length", want.orig_len, m_axis_tdata[74:11]);
      end
      if (m_axis_tdata[138:75] !== want.pay_len) begin
        note_mismatch("payload_length", want.pay_len, m_axis_tdata[138:75]);
      end
      if (m_axis_tdata[146:139] !== want.type_code) begin
        note_mismatch("type_code", 64'(want.type_code), 64'(m_axis_tdata[146:139]));
      end
      if (want.kind == KIND_STATUS) begin
        records_checked++;
        statuses_seen[want.status] = 1'b1;
      end else begin
        payload_checked++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_step({s_axis_tlast, s_axis_tdata});
        xfer_taken = 1'b1;
        bytes_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (xfer_taken || !s_axis_tvalid)) begin
      if (pending_xfers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        {s_axis_tlast, s_axis_tdata} <= pending_xfers.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    xfer_taken = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(input logic [ccd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      ccd_pkg::REG_MAGIC:   cfg_magic   = val;
      ccd_pkg::REG_VERSION: cfg_version = val[7:0];
      ccd_pkg::REG_TYPE_A:  cfg_type_a  = val[7:0];
      ccd_pkg::REG_TYPE_B:  cfg_type_b  = val[7:0];
      ccd_pkg::REG_TYPE_C:  cfg_type_c  = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending_xfers.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic flush_stage();
    for (int i = 0; i < stage_q.size(); i++) begin
      pending_xfers.insert(pending_xfers.size(), {i == stage_q.size() - 1, stage_q[i]});
    end
    bytes_queued += stage_q.size();
    stage_q.delete();
    streams_built++;
  endtask

  task automatic make_frame(input frame_flaw_e flaw);
    logic [7:0]  hdr [ccd_pkg::HDR_BYTES];
    logic [31:0] magic;
    logic [7:0]  ver;
    logic [7:0]  typ;
    logic [63:0] orig;
    logic [63:0] plen;
    logic [31:0] hcrc;
    logic [31:0] pcrc;
    logic [7:0]  b;
    int unsigned n_pay;
    int unsigned keep;
    magic = cfg_magic;
    ver   = cfg_version;
    case ($urandom_range(2))
      0:       typ = cfg_type_a;
      1:       typ = cfg_type_b;
      default: typ = cfg_type_c;
    endcase
    if (flaw == FR_BAD_MAGIC) begin
      magic = magic ^ (32'd1 << $urandom_range(31));
    end
    if (flaw == FR_BAD_VERSION) begin
      ver = ver ^ (8'd1 << $urandom_range(7));
    end
    if (flaw == FR_BAD_TYPE) begin
      do begin
        typ = 8'($urandom);
      end while (typ == cfg_type_a || typ == cfg_type_b || typ == cfg_type_c);
    end
    n_pay = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4);
    if (flaw == FR_CUT_PAYLOAD && n_pay == 0) begin
      n_pay = 1;
    end
    plen = 64'(n_pay);
    if (flaw == FR_HUGE_LENGTH) begin
      plen = $urandom_range(1) ? '1 : ({$urandom, $urandom} | 64'h1_0000_0000);
    end
    case ($urandom_range(3))
      0:       orig = '0;
      1:       orig = '1;
      default: orig = {$urandom, $urandom};
    endcase
    for (int i = 0; i < ccd_pkg::HDR_BYTES; i++) begin
      hdr[i] = 8'($urandom);
    end
    for (int i = 0; i < 4; i++) begin
      hdr[i] = magic[8*i +: 8];
    end
    hdr[VERSION_OFFSET] = ver;
    hdr[TYPE_OFFSET]    = typ;
    for (int i = 0; i < 8; i++) begin
      hdr[ORIG_OFFSET + i] = orig[8*i +: 8];
      hdr[LEN_OFFSET + i]  = plen[8*i +: 8];
    end
    hcrc = CRC32_MASK;
    for (int i = 0; i < ccd_pkg::HDR_BYTES; i++) begin
      hcrc = crc32_update(hcrc, (i == PAD_OFFSET || i >= HCRC_OFFSET) ? 8'h00 : hdr[i]);
    end
    hcrc = hcrc ^ CRC32_MASK;
    if (flaw == FR_BAD_HDR_CRC) begin
      hcrc = hcrc ^ (32'd1 << $urandom_range(31));
    end
    for (int i = 0; i < CRC_BYTES; i++) begin
      hdr[HCRC_OFFSET + i] = hcrc[8*i +: 8];
    end
    for (int i = 0; i < ccd_pkg::HDR_BYTES; i++) begin
      stage_q.insert(stage_q.size(), hdr[i]);
    end
    pcrc = CRC32_MASK;
    for (int i = 0; i < n_pay; i++) begin
      b    = 8'($urandom);
      pcrc = crc32_update(pcrc, b);
      stage_q.insert(stage_q.size(), b);
    end
    pcrc = pcrc ^ CRC32_MASK;
    if (flaw == FR_BAD_PAY_CRC) begin
      pcrc = pcrc ^ (32'd1 << $urandom_range(31));
    end
    for (int i = 0; i < CRC_BYTES; i++) begin
      stage_q.insert(stage_q.size(), pcrc[8*i +: 8]);
    end
    keep = stage_q.size();
    case (flaw)
      FR_CUT_HEADER:  keep = $urandom_range(1, MIN_FRAME - 1);
      FR_CUT_PAYLOAD: keep = $urandom_range(ccd_pkg::HDR_BYTES + 1, MIN_FRAME - 1 + n_pay);
      default: ;
    endcase
    while (stage_q.size() > keep) begin
      void'(stage_q.pop_back());
    end
    if (flaw == FR_TRAILING) begin
      repeat ($urandom_range(1, 3)) stage_q.insert(stage_q.size(), 8'($urandom));
    end
    if (flaw == FR_NOISE) begin
      stage_q.delete();
      repeat ($urandom_range(1, 48)) stage_q.insert(stage_q.size(), 8'($urandom));
    end
    flush_stage();
  endtask

  initial begin
    logic [31:0] junk;
    int unsigned phase_start;
    int unsigned phase_streams;
    int unsigned rot;
    send_idle_pct = 19;
    recv_idle_pct = 84;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short streams under the reset settings.
    stage_q.insert(stage_q.size(), 8'hFF);
    flush_stage();
    stage_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h02};
    flush_stage();
    for (int i = 0; i < 18; i++) begin
      stage_q.insert(stage_q.size(), 8'(i * 8'h1D));
    end
    flush_stage();
    wait_idle();

    rot = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      junk = $urandom;
      case (ph)
        0: begin
          write_reg(ccd_pkg::REG_MAGIC, 32'hFFFF_FFFF);
          write_reg(ccd_pkg::REG_VERSION, {junk[31:8], 8'hFF});
          write_reg(ccd_pkg::REG_TYPE_A, 32'h0000_00FF);
          write_reg(ccd_pkg::REG_TYPE_B, {junk[23:0], 8'h00});
          write_reg(ccd_pkg::REG_TYPE_C, $urandom);
          write_reg(ccd_pkg::CFG_IDX_BITS'($urandom_range(int'(ccd_pkg::REG_TYPE_C) + 1,
                                           (1 << ccd_pkg::CFG_IDX_BITS) - 1)), $urandom);
        end
        1: begin
          write_reg(ccd_pkg::REG_MAGIC, $urandom);
          write_reg(ccd_pkg::REG_VERSION, $urandom);
          write_reg(ccd_pkg::REG_TYPE_A, $urandom);
          write_reg(ccd_pkg::REG_TYPE_B, $urandom);
          write_reg(ccd_pkg::REG_TYPE_C, $urandom);
        end
        default: begin
          write_reg(ccd_pkg::REG_MAGIC, 32'h0000_0000);
          write_reg(ccd_pkg::REG_VERSION, {junk[31:8], 8'h00});
          write_reg(ccd_pkg::REG_TYPE_A, 32'h0000_0000);
          write_reg(ccd_pkg::REG_TYPE_B, 32'h0000_00FF);
          write_reg(ccd_pkg::REG_TYPE_C, $urandom);
        end
      endcase
      @(posedge clk);
      phase_start   = bytes_queued;
      phase_streams = 0;
      while (bytes_queued - phase_start < TARGET_BYTES / 3 || phase_streams < MIN_STREAMS) begin
        make_frame((rot % FLAW_ROTATION > int'(FR_NOISE)) ? FR_GOOD :
                   frame_flaw_e'(rot % FLAW_ROTATION));
        rot++;
        phase_streams++;
      end
      wait_idle();
    end

    $display("Sent %0d bytes in %0d streams across three register settings.",
             bytes_accepted, streams_built);
    $display("Checked %0d forwarded bytes and %0d status records (codes seen %b).",
             payload_checked, records_checked, statuses_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
